// ===== rtl/assert_macros.svh =====
// assertion macros for the rtl files, included by sorted_interval_table_lookup
// expects clk and rst_n in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sitl_pkg.sv =====
// types and constants of the sorted interval table
// no dependencies
package sitl_pkg;

    // table depth and derived widths
    localparam int MAX_ENTRIES = 1024;
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

    // field widths
    localparam int CHROM_W = 8;
    localparam int POS_W = 32;
    localparam int CLASS_W = 3;
    localparam int OUT_IDX_W = 10;
    localparam int OP_W = 2;

    // stream payload widths
    localparam int S_DATA_W = 112;
    localparam int S_USER_W = OP_W;
    localparam int M_DATA_W = 80;
    localparam int M_USER_W = 2;

    // operation codes carried in the input tuser
    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_LOOKUP = 2'd2
    } op_t;

    // one stored table entry
    typedef struct packed {
        logic [CHROM_W-1:0] chrom;
        logic [POS_W-1:0]   start;
        logic [POS_W-1:0]   stop;
        logic [CLASS_W-1:0] rep_class;
    } entry_t;

endpackage

// ===== rtl/sorted_interval_table_lookup.sv =====
// Lookup: S binary search steps, S at most ceil(log2(count + 1)), then a hit check of one entry;
// insert: search, then M entries moved up by one; clear, full insert and unused code: result only.
// Throughput: one transaction at a time; each search step and each moved entry takes a read
// of the table memory (one read and one write port), then a compare or a write back.
// Reset: asynchronous active low, empties the table (count to zero) and drops any pending
// result; memory contents are not cleared, entries above the count are never read.
// sorted interval table with binary search lookup and shifting insert
// depends on sitl_pkg and assert_macros.svh
`include "assert_macros.svh"

module sorted_interval_table_lookup (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // chrom_id[7:0], start_pos[39:8], end_pos[71:40], repeat_class[74:72],
    // query_pos[106:75], zero fill above
    input  logic [sitl_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // operation[1:0]
    input  logic [sitl_pkg::S_USER_W-1:0]  s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // entry_index[9:0], hit_class[12:10], hit_start[44:13], hit_end[76:45], zero fill above
    output logic [sitl_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // hit[0], table_full[1]
    output logic [sitl_pkg::M_USER_W-1:0]  m_axis_tuser
);
    import sitl_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_SRCH_CMP,
        ST_LK_CHK,
        ST_SH_RD,
        ST_SH_WR,
        ST_DONE
    } state_t;

    // control and item registers
    state_t               state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [CHROM_W-1:0]   chrom_reg, chrom_next;
    logic [POS_W-1:0]     key_pos_reg, key_pos_next;
    entry_t               new_reg, new_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     lo_reg, lo_next;
    logic [CNT_W-1:0]     hi_reg, hi_next;
    logic [CNT_W-1:0]     mid_reg, mid_next;
    logic [CNT_W-1:0]     k_reg, k_next;

    // pending result
    logic                 res_hit_reg, res_hit_next;
    logic                 res_full_reg, res_full_next;
    logic [OUT_IDX_W-1:0] res_index_reg, res_index_next;
    entry_t               res_entry_reg, res_entry_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]  m_data_reg, m_data_next;
    logic [M_USER_W-1:0]  m_user_reg, m_user_next;

    // table memory ports
    entry_t               mem_q [MAX_ENTRIES];
    entry_t               rd_data_reg;
    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic                 wr_en;
    logic [IDX_W-1:0]     wr_addr;
    entry_t               wr_data;

    logic [CNT_W-1:0]     mid;
    logic                 key_above;
    logic                 in_hit;
    logic                 in_fire;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata = m_data_reg;
    assign m_axis_tuser = m_user_reg;

    // search midpoint and key compare against the entry just read
    assign mid = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign key_above = (rd_data_reg.chrom != chrom_reg) ? (rd_data_reg.chrom > chrom_reg)
                                                        : (rd_data_reg.start > key_pos_reg);
    assign in_hit = (rd_data_reg.chrom == chrom_reg) && (rd_data_reg.start <= key_pos_reg)
                    && (key_pos_reg < rd_data_reg.stop);

    // table memory, one read and one write port, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_q[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_q[rd_addr];
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg;
        chrom_next = chrom_reg;
        key_pos_next = key_pos_reg;
        new_next = new_reg;
        count_next = count_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        mid_next = mid_reg;
        k_next = k_reg;
        res_hit_next = res_hit_reg;
        res_full_next = res_full_reg;
        res_index_next = res_index_reg;
        res_entry_next = res_entry_reg;
        m_valid_next = m_valid_reg;
        m_data_next = m_data_reg;
        m_user_next = m_user_reg;
        rd_en = 1'b0;
        rd_addr = mid[IDX_W-1:0];
        wr_en = 1'b0;
        wr_addr = k_reg[IDX_W-1:0];
        wr_data = rd_data_reg;

        // output register drains independently of the sequencer
        if (m_valid_reg && m_axis_tready)
        begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    op_next = op_t'(s_axis_tuser);
                    chrom_next = s_axis_tdata[7:0];
                    new_next.chrom = s_axis_tdata[7:0];
                    new_next.start = s_axis_tdata[39:8];
                    new_next.stop = s_axis_tdata[71:40];
                    new_next.rep_class = s_axis_tdata[74:72];
                    res_hit_next = 1'b0;
                    res_full_next = 1'b0;
                    res_index_next = '0;
                    res_entry_next = '0;
                    lo_next = '0;
                    hi_next = count_reg;
                    state_next = ST_DONE;
                    case (op_t'(s_axis_tuser))
                        OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        OP_INSERT:
                        begin
                            key_pos_next = s_axis_tdata[39:8];
                            if (count_reg == CNT_W'(MAX_ENTRIES))
                            begin
                                res_full_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_SRCH;
                            end
                        end
                        OP_LOOKUP:
                        begin
                            key_pos_next = s_axis_tdata[106:75];
                            state_next = ST_SRCH;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en = 1'b1;
                    rd_addr = mid[IDX_W-1:0];
                    mid_next = mid;
                    state_next = ST_SRCH_CMP;
                end
                else if (op_reg == OP_LOOKUP)
                begin
                    if (lo_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        rd_en = 1'b1;
                        rd_addr = IDX_W'(lo_reg - 1'b1);
                        state_next = ST_LK_CHK;
                    end
                end
                else
                begin
                    k_next = count_reg;
                    state_next = ST_SH_RD;
                end
            end
            ST_SRCH_CMP:
            begin
                if (key_above)
                begin
                    hi_next = mid_reg;
                end
                else
                begin
                    lo_next = mid_reg + 1'b1;
                end
                state_next = ST_SRCH;
            end
            ST_LK_CHK:
            begin
                if (in_hit)
                begin
                    res_hit_next = 1'b1;
                    res_index_next = OUT_IDX_W'(lo_reg - 1'b1);
                    res_entry_next = rd_data_reg;
                end
                state_next = ST_DONE;
            end
            ST_SH_RD:
            begin
                if (k_reg > lo_reg)
                begin
                    rd_en = 1'b1;
                    rd_addr = IDX_W'(k_reg - 1'b1);
                    state_next = ST_SH_WR;
                end
                else
                begin
                    // new entry lands after all keys at or below it
                    wr_en = 1'b1;
                    wr_addr = lo_reg[IDX_W-1:0];
                    wr_data = new_reg;
                    count_next = count_reg + 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_SH_WR:
            begin
                wr_en = 1'b1;
                wr_addr = k_reg[IDX_W-1:0];
                wr_data = rd_data_reg;
                k_next = k_reg - 1'b1;
                state_next = ST_SH_RD;
            end
            ST_DONE:
            begin
                // hand the result over once the output register is free
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_user_next = {res_full_reg, res_hit_reg};
                    m_data_next = {{(M_DATA_W - OUT_IDX_W - CLASS_W - 2 * POS_W){1'b0}},
                                   res_entry_reg.stop, res_entry_reg.start,
                                   res_entry_reg.rep_class, res_index_reg};
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            op_reg <= OP_CLEAR;
            chrom_reg <= '0;
            key_pos_reg <= '0;
            new_reg <= '0;
            count_reg <= '0;
            lo_reg <= '0;
            hi_reg <= '0;
            mid_reg <= '0;
            k_reg <= '0;
            res_hit_reg <= 1'b0;
            res_full_reg <= 1'b0;
            res_index_reg <= '0;
            res_entry_reg <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg <= '0;
            m_user_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg <= op_next;
            chrom_reg <= chrom_next;
            key_pos_reg <= key_pos_next;
            new_reg <= new_next;
            count_reg <= count_next;
            lo_reg <= lo_next;
            hi_reg <= hi_next;
            mid_reg <= mid_next;
            k_reg <= k_next;
            res_hit_reg <= res_hit_next;
            res_full_reg <= res_full_next;
            res_index_reg <= res_index_next;
            res_entry_reg <= res_entry_next;
            m_valid_reg <= m_valid_next;
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    // checks
    `ASSERT_CLK(a_count_bound, (count_reg <= CNT_W'(MAX_ENTRIES)), "entry count above depth")
    `ASSERT_IMPL(a_wr_in_table, wr_en, (CNT_W'(wr_addr) <= count_reg), "write beyond table fill")
    `ASSERT_IMPL(a_hit_not_full, m_valid_reg, !(m_user_reg[0] && m_user_reg[1]),
                 "hit and table full on one result")
    `ASSERT_IMPL(a_search_bounds, (state_reg == ST_SRCH), (hi_reg <= count_reg),
                 "search bound past table fill")

endmodule
